FILE: hw/rtl/tmb_pkg.sv
// ----------------------------------------------------------------------------
// tmb_pkg - shared constants for the trimmed mean of batch unit
// Field widths, default batch shape and the digit size of the mean divider.
// ----------------------------------------------------------------------------
package tmb_pkg;

  // field and state widths
  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 37;
  localparam int MEAN_W   = 40;
  localparam int COUNT_W  = 5;
  localparam int FRAC_W   = 8;

  // quotient bits produced per divider cycle
  localparam int DIG_W    = 8;

  // default batch shape
  localparam int BATCH_SIZE_DEF     = 28;
  localparam int SKIP_FIRST_DEF     = 2;
  localparam int TRIM_EACH_SIDE_DEF = 3;

endpackage

FILE: hw/rtl/tmb_cell.sv
// ----------------------------------------------------------------------------
// tmb_cell - one slot of an extreme-value tracker chain
// Holds one entry of a sorted list. On each tracked beat it takes its
// neighbour's entry if the sample beats that, else the sample if it beats its
// own entry, so the list stays sorted and the displaced entry moves down.
// ----------------------------------------------------------------------------
module tmb_cell #(
  parameter bit DESCEND = 1'b0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         clr,
  input  logic [tmb_pkg::SAMPLE_W-1:0] sample,
  input  logic [tmb_pkg::SAMPLE_W-1:0] prev_entry,
  output logic [tmb_pkg::SAMPLE_W-1:0] entry,
  output logic [tmb_pkg::SAMPLE_W-1:0] entry_upd
);

  // empty value: all ones for the smallest list, zero for the largest
  localparam logic [tmb_pkg::SAMPLE_W-1:0] EMPTY_VAL =
    DESCEND ? '0 : '1;

  logic [tmb_pkg::SAMPLE_W-1:0] entry_r;
  logic [tmb_pkg::SAMPLE_W-1:0] entry_nxt;
  logic                         beats_prev;
  logic                         beats_own;

  // strict compares, so equal values keep their earlier place
  always_comb begin
    if (DESCEND) begin
      beats_prev = sample > prev_entry;
      beats_own  = sample > entry_r;
    end else begin
      beats_prev = sample < prev_entry;
      beats_own  = sample < entry_r;
    end
  end

  always_comb begin
    if (!en) begin
      entry_upd = entry_r;
    end else if (beats_prev) begin
      entry_upd = prev_entry;
    end else if (beats_own) begin
      entry_upd = sample;
    end else begin
      entry_upd = entry_r;
    end
    entry_nxt = clr ? EMPTY_VAL : entry_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= EMPTY_VAL;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

FILE: hw/rtl/tmb_mean.sv
// ----------------------------------------------------------------------------
// tmb_mean - trim and divide unit with output register
// Takes a snapshot of the batch sum and tracked extremes, accumulates the
// extremes one per cycle, removes them from the sum and divides the scaled
// result by the kept count, one digit per cycle.
// ----------------------------------------------------------------------------
module tmb_mean #(
  parameter int BATCH_SIZE     = tmb_pkg::BATCH_SIZE_DEF,
  parameter int SKIP_FIRST     = tmb_pkg::SKIP_FIRST_DEF,
  parameter int TRIM_EACH_SIDE = tmb_pkg::TRIM_EACH_SIDE_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            start,
  input  logic [tmb_pkg::SUM_W-1:0]                       snap_sum,
  input  logic [2*TRIM_EACH_SIDE-1:0][tmb_pkg::SAMPLE_W-1:0] snap_ext,
  output logic                                            idle,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic [tmb_pkg::MEAN_W-1:0]                      out_mean_q8
);

  localparam int N_EXT   = 2 * TRIM_EACH_SIDE;
  localparam int KEPT    = BATCH_SIZE - SKIP_FIRST - 2 * TRIM_EACH_SIDE;
  localparam bit KEPT_OK = KEPT > 0;
  localparam int DIV_K   = KEPT_OK ? KEPT : 1;
  localparam int REM_W   = $clog2(DIV_K + 1);
  localparam int EXT_CW  = $clog2(N_EXT);
  localparam int TRIM_W  = tmb_pkg::SAMPLE_W + $clog2(N_EXT);
  localparam int DIVD_W  = tmb_pkg::SUM_W + tmb_pkg::FRAC_W;
  localparam int NCHUNK  = (DIVD_W + tmb_pkg::DIG_W - 1) / tmb_pkg::DIG_W;
  localparam int PAD_W   = NCHUNK * tmb_pkg::DIG_W;
  localparam int CHK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  localparam logic [REM_W:0]        K_VAL    = (REM_W + 1)'(DIV_K);
  localparam logic [EXT_CW-1:0]     EXT_LAST = EXT_CW'(N_EXT - 1);
  localparam logic [CHK_W-1:0]      CHK_LAST = CHK_W'(NCHUNK - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIM,
    S_MID,
    S_DIV,
    S_DONE
  } state_t;

  state_t                                       state_r, state_nxt;
  logic [N_EXT-1:0][tmb_pkg::SAMPLE_W-1:0]      ext_r, ext_nxt;
  logic [tmb_pkg::SUM_W-1:0]                    sum_r, sum_nxt;
  logic [TRIM_W-1:0]                            trim_r, trim_nxt;
  logic [EXT_CW-1:0]                            ext_cnt_r, ext_cnt_nxt;
  logic [CHK_W-1:0]                             chk_cnt_r, chk_cnt_nxt;
  logic [PAD_W-1:0]                             divd_r, divd_nxt;
  logic [PAD_W-1:0]                             quot_r, quot_nxt;
  logic [REM_W-1:0]                             rem_r, rem_nxt;
  logic                                         out_valid_r, out_valid_nxt;
  logic [tmb_pkg::MEAN_W-1:0]                   mean_r, mean_nxt;

  logic [tmb_pkg::SUM_W-1:0]                    trim_ext;
  logic [tmb_pkg::SUM_W-1:0]                    middle;
  logic [tmb_pkg::DIG_W-1:0]                    digit;
  logic [REM_W-1:0]                             rem_step;

  // sum less extremes, clamped at zero
  assign trim_ext = tmb_pkg::SUM_W'(trim_r);
  assign middle   = (sum_r >= trim_ext) ? (sum_r - trim_ext) : '0;

  // one quotient digit: restoring division by the kept count, MSB first
  always_comb begin
    logic [REM_W:0] trial;
    rem_step = rem_r;
    digit    = '0;
    for (int k = 0; k < tmb_pkg::DIG_W; k++) begin
      trial = {rem_step, divd_r[PAD_W-1-k]};
      if (trial >= K_VAL) begin
        trial                          = trial - K_VAL;
        digit[tmb_pkg::DIG_W-1-k]      = 1'b1;
      end
      rem_step = trial[REM_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ext_nxt       = ext_r;
    sum_nxt       = sum_r;
    trim_nxt      = trim_r;
    ext_cnt_nxt   = ext_cnt_r;
    chk_cnt_nxt   = chk_cnt_r;
    divd_nxt      = divd_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    mean_nxt      = mean_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          ext_nxt     = snap_ext;
          sum_nxt     = snap_sum;
          trim_nxt    = '0;
          ext_cnt_nxt = '0;
          state_nxt   = S_TRIM;
        end
      end
      S_TRIM: begin
        trim_nxt = trim_r + TRIM_W'(ext_r[0]);
        for (int i = 0; i < N_EXT - 1; i++) begin
          ext_nxt[i] = ext_r[i+1];
        end
        ext_nxt[N_EXT-1] = '0;
        ext_cnt_nxt      = ext_cnt_r + 1'b1;
        if (ext_cnt_r == EXT_LAST) begin
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        divd_nxt    = PAD_W'({middle, tmb_pkg::FRAC_W'(0)});
        quot_nxt    = '0;
        rem_nxt     = '0;
        chk_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        divd_nxt    = divd_r << tmb_pkg::DIG_W;
        quot_nxt    = {quot_r[PAD_W-tmb_pkg::DIG_W-1:0], digit};
        rem_nxt     = rem_step;
        chk_cnt_nxt = chk_cnt_r + 1'b1;
        if (chk_cnt_r == CHK_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // load the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          mean_nxt      = KEPT_OK ? quot_r[tmb_pkg::MEAN_W-1:0] : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ext_r     <= ext_nxt;
    sum_r     <= sum_nxt;
    trim_r    <= trim_nxt;
    ext_cnt_r <= ext_cnt_nxt;
    chk_cnt_r <= chk_cnt_nxt;
    divd_r    <= divd_nxt;
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    mean_r    <= mean_nxt;
  end

  assign idle        = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_mean_q8 = mean_r;

endmodule

FILE: hw/rtl/trimmed_mean_of_batch_unit.sv
// ----------------------------------------------------------------------------
// trimmed_mean_of_batch_unit - trimmed mean of a batch of timing samples
// Flow: after the last beat of a batch the mean unit removes the extremes, then
//   divides in NCHUNK = 6 divider digits and loads the output register.
// Throughput: one sample beat per cycle; the last beat of a batch waits only
//   while the previous batch's trim and divide unit is still busy.
// Reset: synchronous active low; clears the batch position, sum and trackers.
// ----------------------------------------------------------------------------
module trimmed_mean_of_batch_unit #(
  parameter int BATCH_SIZE     = tmb_pkg::BATCH_SIZE_DEF,
  parameter int SKIP_FIRST     = tmb_pkg::SKIP_FIRST_DEF,
  parameter int TRIM_EACH_SIDE = tmb_pkg::TRIM_EACH_SIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tmb_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tmb_pkg::MEAN_W-1:0]   out_mean_q8
);

  localparam logic [tmb_pkg::COUNT_W-1:0] POS_SKIP =
    tmb_pkg::COUNT_W'(SKIP_FIRST);
  localparam logic [tmb_pkg::COUNT_W-1:0] POS_LAST =
    tmb_pkg::COUNT_W'(BATCH_SIZE - 1);

  logic [tmb_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [tmb_pkg::SUM_W-1:0]   sum_r, sum_nxt, sum_upd;

  logic in_fire;
  logic is_last;
  logic track_en;
  logic batch_end;
  logic mean_idle;

  logic [TRIM_EACH_SIDE:0][tmb_pkg::SAMPLE_W-1:0]     lo_chain;
  logic [TRIM_EACH_SIDE:0][tmb_pkg::SAMPLE_W-1:0]     hi_chain;
  logic [TRIM_EACH_SIDE-1:0][tmb_pkg::SAMPLE_W-1:0]   lo_upd;
  logic [TRIM_EACH_SIDE-1:0][tmb_pkg::SAMPLE_W-1:0]   hi_upd;
  logic [2*TRIM_EACH_SIDE-1:0][tmb_pkg::SAMPLE_W-1:0] snap_ext;

  // beat control: last beat of a batch needs the mean unit free
  assign is_last   = (count_r >= POS_LAST);
  assign in_ready  = !is_last || mean_idle;
  assign in_fire   = in_valid && in_ready;
  assign track_en  = in_fire && (count_r >= POS_SKIP);
  assign batch_end = in_fire && is_last;

  // position and running sum
  always_comb begin
    sum_upd   = track_en ? (sum_r + tmb_pkg::SUM_W'(in_sample)) : sum_r;
    sum_nxt   = batch_end ? '0 : sum_upd;
    count_nxt = count_r;
    if (batch_end) begin
      count_nxt = '0;
    end else if (in_fire) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // tracker chains; the head's neighbour value never wins
  assign lo_chain[0] = '0;
  assign hi_chain[0] = '1;

  for (genvar i = 0; i < TRIM_EACH_SIDE; i++) begin : g_track
    tmb_cell #(
      .DESCEND (1'b0)
    ) u_lo_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (track_en),
      .clr        (batch_end),
      .sample     (in_sample),
      .prev_entry (lo_chain[i]),
      .entry      (lo_chain[i+1]),
      .entry_upd  (lo_upd[i])
    );

    tmb_cell #(
      .DESCEND (1'b1)
    ) u_hi_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (track_en),
      .clr        (batch_end),
      .sample     (in_sample),
      .prev_entry (hi_chain[i]),
      .entry      (hi_chain[i+1]),
      .entry_upd  (hi_upd[i])
    );

    assign snap_ext[i]                  = lo_upd[i];
    assign snap_ext[TRIM_EACH_SIDE + i] = hi_upd[i];
  end

  // trim, divide and hold the result
  tmb_mean #(
    .BATCH_SIZE     (BATCH_SIZE),
    .SKIP_FIRST     (SKIP_FIRST),
    .TRIM_EACH_SIDE (TRIM_EACH_SIDE)
  ) u_mean (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (batch_end),
    .snap_sum    (sum_upd),
    .snap_ext    (snap_ext),
    .idle        (mean_idle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_mean_q8 (out_mean_q8)
  );

endmodule
